// File: rtl/msq_pkg.sv
package msq_pkg;

  localparam int ADDR_BITS   = 22;
  localparam int DATA_BITS   = 32;
  localparam int REGION_BITS = ADDR_BITS + 1;
  localparam int SAVE_DEPTH  = 32;
  localparam int SAVE_IDX_W  = $clog2(SAVE_DEPTH);
  localparam int SAVE_CNT_W  = $clog2(SAVE_DEPTH + 1);
  localparam int SHIFT_W     = 5;
  localparam int GAP_BITS    = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = REGION_BITS;

  localparam logic [DATA_BITS-1:0] PAT_A = 32'hAAAA_AAAA;
  localparam logic [DATA_BITS-1:0] PAT_5 = 32'h5555_5555;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_STEP   = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [1:0] OP_IDLE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_DONE  = 2'd3;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_PASS = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;
  localparam logic [1:0] ST_SKIP = 2'd3;

  localparam logic [1:0] SUB_DATA = 2'd0;
  localparam logic [1:0] SUB_ADDR = 2'd1;
  localparam logic [1:0] SUB_DEV  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_WORD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_WORDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUICK_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SAFE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_HIGH    = 3'd5;

  typedef enum logic [4:0] {
    PH_IDLE, PH_END, DB_ORIG, DB_WR, DB_RD, DB_RESTORE,
    AB_SAVE, AB_WA, AB_W5, AB_VR, AB_WBA, AB_TW, AB_TRB, AB_TRO, AB_TWA, AB_RS,
    DD_W, DD_R1, DD_WI, DD_R2,
    DS_RO, DS_W1, DS_R1, DS_W2, DS_R2, DS_WO
  } phase_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]   base_word;
    logic [REGION_BITS-1:0] region_words;
    logic                   quick_mode;
    logic                   device_safe;
    logic [REGION_BITS-1:0] skip_low;
    logic [REGION_BITS-1:0] skip_high;
  } cfg_t;

  typedef struct packed {
    phase_t                 phase;
    logic [1:0]             subtest;
    logic [ADDR_BITS-1:0]   probe;
    logic [ADDR_BITS-1:0]   stuck;
    logic [REGION_BITS-1:0] widx;
    logic [DATA_BITS-1:0]   pat;
    logic [DATA_BITS-1:0]   orig;
    logic [SAVE_CNT_W-1:0]  save_cnt;
    logic [1:0]             status;
    logic                   failed;
    logic                   cancel;
    logic [1:0]             f_sub;
    logic [ADDR_BITS-1:0]   f_addr;
    logic [DATA_BITS-1:0]   f_exp;
    logic [DATA_BITS-1:0]   f_act;
  } state_t;

  typedef struct packed {
    logic [1:0]           mem_op;
    logic [ADDR_BITS-1:0] mem_address;
    logic [DATA_BITS-1:0] write_data;
    logic [1:0]           run_status;
    logic [1:0]           fail_subtest;
    logic [ADDR_BITS-1:0] fail_address;
    logic [DATA_BITS-1:0] expected_word;
    logic [DATA_BITS-1:0] actual_word;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic [SAVE_IDX_W-1:0] idx;
    logic [DATA_BITS-1:0]  data;
  } save_wr_t;

  function automatic logic [ADDR_BITS-1:0] waddr(input logic [ADDR_BITS-1:0] base,
                                                 input logic [ADDR_BITS-1:0] off);
    return base + off;
  endfunction

  function automatic logic in_skip(input logic [ADDR_BITS-1:0] a,
                                   input logic [REGION_BITS-1:0] lo,
                                   input logic [REGION_BITS-1:0] hi);
    return (hi > lo) && ({1'b0, a} >= lo) && ({1'b0, a} < hi);
  endfunction

  function automatic logic [DATA_BITS-1:0] dpat(input logic [REGION_BITS-1:0] i);
    return DATA_BITS'(i) + 1'b1;
  endfunction

endpackage

// File: rtl/msq_in_if.sv
interface msq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] read_data;

  modport source (output valid, output command, output read_data, input ready);
  modport sink (input valid, input command, input read_data, output ready);
endinterface

// File: rtl/msq_out_if.sv
interface msq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mem_op;
  logic [21:0] mem_address;
  logic [31:0] write_data;
  logic [1:0]  run_status;
  logic [1:0]  fail_subtest;
  logic [21:0] fail_address;
  logic [31:0] expected_word;
  logic [31:0] actual_word;

  modport source (output valid, output mem_op, output mem_address, output write_data,
                  output run_status, output fail_subtest, output fail_address,
                  output expected_word, output actual_word, input ready);
  modport sink (input valid, input mem_op, input mem_address, input write_data,
                input run_status, input fail_subtest, input fail_address,
                input expected_word, input actual_word, output ready);
endinterface

// File: rtl/msq_offset_scan.sv
module msq_offset_scan (
  input  msq_pkg::cfg_t                     cfg,
  input  logic [msq_pkg::ADDR_BITS-1:0]     from_off,
  input  logic [msq_pkg::ADDR_BITS-1:0]     excl_off,
  output logic                              found,
  output logic [msq_pkg::ADDR_BITS-1:0]     off
);
  import msq_pkg::*;

  logic [REGION_BITS-1:0] region_m1;
  logic [ADDR_BITS-1:0]   mask, ge, fail, limit, elig, skipv, cand;

  assign region_m1 = cfg.region_words - 1'b1;
  assign mask      = region_m1[ADDR_BITS-1:0];

  // offsets at or above the start, cut at the first one outside the mask
  assign ge    = (from_off == '0) ? '0 : ~(from_off - 1'b1);
  assign fail  = ge & ~mask;
  assign limit = fail & (~fail + 1'b1);
  assign elig  = (fail == '0) ? ge : (ge & (limit - 1'b1));

  always_comb begin
    for (int k = 0; k < ADDR_BITS; k++) begin
      skipv[k] = in_skip(waddr(cfg.base_word, ADDR_BITS'(1) << k), cfg.skip_low, cfg.skip_high);
    end
  end

  assign cand  = elig & ~skipv & ~excl_off;
  assign found = |cand;
  assign off   = cand & (~cand + 1'b1);
endmodule

// File: rtl/msq_step.sv
module msq_step (
  input  msq_pkg::cfg_t                  cfg,
  input  msq_pkg::state_t                st,
  input  logic [1:0]                     command,
  input  logic [msq_pkg::DATA_BITS-1:0]  rd,
  input  logic [msq_pkg::DATA_BITS-1:0]  saved_rd,
  input  logic [msq_pkg::DATA_BITS-1:0]  saved0,
  output msq_pkg::state_t                nxt,
  output msq_pkg::res_t                  res,
  output msq_pkg::save_wr_t              sv_wr
);
  import msq_pkg::*;

  logic [ADDR_BITS-1:0] a_from, a_excl, a_off, b_off;
  logic                 a_found, b_found;

  always_comb begin
    a_excl = '0;
    case (st.phase)
      AB_WA, AB_VR:  a_from = st.stuck << 1;
      AB_TRO: begin
        a_from = st.stuck << 1;
        a_excl = st.probe;
      end
      AB_TRB: begin
        a_from = ADDR_BITS'(1);
        a_excl = st.probe;
      end
      AB_TWA:        a_from = st.probe << 1;
      default:       a_from = ADDR_BITS'(1);
    endcase
  end

  msq_offset_scan u_scan_a (
    .cfg(cfg), .from_off(a_from), .excl_off(a_excl), .found(a_found), .off(a_off)
  );

  msq_offset_scan u_scan_b (
    .cfg(cfg), .from_off(ADDR_BITS'(1)), .excl_off('0), .found(b_found), .off(b_off)
  );

  always_comb begin
    logic                   f_wa, f_b5, f_vera, f_verb, f_basea, f_testa, f_innera;
    logic                   f_restore, f_after, f_dev, f_dsword, f_fin, skip0, mism;
    logic [ADDR_BITS-1:0]   a0, roff;
    logic [REGION_BITS-1:0] ni, rm1;
    logic [DATA_BITS-1:0]   expw;
    logic [SAVE_CNT_W-1:0]  wi1;
    f_wa = 1'b0; f_b5 = 1'b0; f_vera = 1'b0; f_verb = 1'b0; f_basea = 1'b0;
    f_testa = 1'b0; f_innera = 1'b0; f_restore = 1'b0; f_after = 1'b0; f_dev = 1'b0;
    f_dsword = 1'b0; f_fin = 1'b0;
    a0    = cfg.base_word;
    skip0 = in_skip(a0, cfg.skip_low, cfg.skip_high);
    ni    = st.widx + 1'b1;
    rm1   = cfg.region_words - 1'b1;
    expw  = dpat(st.widx);
    mism  = 1'b0;
    wi1   = SAVE_CNT_W'(st.widx) + 1'b1;
    roff  = ADDR_BITS'(1) << SHIFT_W'(st.widx - 1'b1);
    nxt   = st;
    sv_wr = '{we: 1'b0, idx: st.widx[SAVE_IDX_W-1:0], data: rd};
    res   = '0;
    res.mem_op = OP_IDLE;

    case (command)
      CMD_START: begin
        nxt.failed = 1'b0; nxt.cancel = 1'b0; nxt.status = ST_RUN;
        nxt.f_sub = '0; nxt.f_addr = '0; nxt.f_exp = '0; nxt.f_act = '0;
        nxt.subtest = SUB_DATA;
        res.mem_op = OP_READ; res.mem_address = a0; nxt.phase = DB_ORIG;
      end
      CMD_CANCEL: begin
        if (st.phase != PH_IDLE) nxt.cancel = 1'b1;
      end
      CMD_STEP: begin
        case (st.phase)
          PH_IDLE: ;
          PH_END:  f_fin = 1'b1;
          DB_ORIG: begin
            nxt.orig = rd; nxt.pat = DATA_BITS'(1);
            res.mem_op = OP_WRITE; res.mem_address = a0; res.write_data = DATA_BITS'(1);
            nxt.phase = DB_WR;
          end
          DB_WR: begin
            res.mem_op = OP_READ; res.mem_address = a0; nxt.phase = DB_RD;
          end
          DB_RD: begin
            res.mem_op = OP_WRITE; res.mem_address = a0;
            if (rd != st.pat) begin
              if (!st.failed) begin
                nxt.failed = 1'b1; nxt.f_sub = SUB_DATA; nxt.f_addr = a0;
                nxt.f_exp = st.pat; nxt.f_act = rd;
              end
              res.write_data = st.orig; nxt.phase = PH_END;
            end else begin
              nxt.pat = st.pat << 1;
              if (nxt.pat != '0) begin
                res.write_data = nxt.pat; nxt.phase = DB_WR;
              end else begin
                res.write_data = st.orig; nxt.phase = DB_RESTORE;
              end
            end
          end
          DB_RESTORE: begin
            nxt.subtest = SUB_ADDR;
            if (st.cancel) f_fin = 1'b1;
            else begin
              nxt.widx = '0; nxt.save_cnt = '0;
              res.mem_op = OP_READ; res.mem_address = a0; nxt.phase = AB_SAVE;
            end
          end
          AB_SAVE: begin
            sv_wr.we = (st.widx < REGION_BITS'(SAVE_DEPTH));
            nxt.widx = ni; nxt.save_cnt = wi1;
            roff = ADDR_BITS'(1) << SHIFT_W'(st.widx);
            if (ni < REGION_BITS'(SAVE_DEPTH) &&
                (roff & rm1[ADDR_BITS-1:0]) != '0) begin
              res.mem_op = OP_READ; res.mem_address = waddr(a0, roff);
              nxt.phase = AB_SAVE;
            end else f_wa = 1'b1;
          end
          AB_WA:  f_wa = 1'b1;
          AB_W5:  f_verb = 1'b1;
          AB_VR: begin
            if (rd != PAT_A) begin
              mism = 1'b1; roff = st.stuck; f_restore = 1'b1;
            end else f_vera = 1'b1;
          end
          AB_WBA: f_testa = 1'b1;
          AB_TW: begin
            res.mem_op = OP_READ; res.mem_address = a0; nxt.phase = AB_TRB;
          end
          AB_TRB: begin
            if (rd != PAT_A) begin
              mism = 1'b1; roff = st.probe; f_restore = 1'b1;
            end else f_innera = 1'b1;
          end
          AB_TRO: begin
            if (rd != PAT_A) begin
              mism = 1'b1; roff = st.stuck; f_restore = 1'b1;
            end else f_innera = 1'b1;
          end
          AB_TWA: f_testa = 1'b1;
          AB_RS: begin
            if (st.widx < REGION_BITS'(st.save_cnt) &&
                st.widx < REGION_BITS'(SAVE_DEPTH)) begin
              res.mem_op = OP_WRITE; res.mem_address = waddr(a0, roff);
              res.write_data = saved_rd; nxt.widx = ni; nxt.phase = AB_RS;
            end else f_after = 1'b1;
          end
          DD_W: begin
            if (ni < cfg.region_words) begin
              nxt.widx = ni; res.mem_op = OP_WRITE;
              res.mem_address = waddr(a0, ni[ADDR_BITS-1:0]);
              res.write_data = dpat(ni); nxt.phase = DD_W;
            end else begin
              nxt.widx = '0; res.mem_op = OP_READ; res.mem_address = a0; nxt.phase = DD_R1;
            end
          end
          DD_R1, DD_R2: begin
            if (st.phase == DD_R2) expw = ~expw;
            if (rd != expw) begin
              if (!st.failed) begin
                nxt.failed = 1'b1; nxt.f_sub = SUB_DEV;
                nxt.f_addr = waddr(a0, st.widx[ADDR_BITS-1:0]);
                nxt.f_exp = expw; nxt.f_act = rd;
              end
              f_fin = 1'b1;
            end else if (st.phase == DD_R1) begin
              res.mem_op = OP_WRITE; res.mem_address = waddr(a0, st.widx[ADDR_BITS-1:0]);
              res.write_data = ~expw; nxt.phase = DD_WI;
            end else begin
              nxt.widx = ni;
              if (ni < cfg.region_words) begin
                res.mem_op = OP_READ; res.mem_address = waddr(a0, ni[ADDR_BITS-1:0]);
                nxt.phase = DD_R2;
              end else f_fin = 1'b1;
            end
          end
          DD_WI: begin
            if (ni < cfg.region_words) begin
              nxt.widx = ni; res.mem_op = OP_READ;
              res.mem_address = waddr(a0, ni[ADDR_BITS-1:0]); nxt.phase = DD_R1;
            end else begin
              nxt.widx = '0; res.mem_op = OP_READ; res.mem_address = a0; nxt.phase = DD_R2;
            end
          end
          DS_RO: begin
            nxt.orig = rd; nxt.pat = expw;
            res.mem_op = OP_WRITE; res.mem_address = waddr(a0, st.widx[ADDR_BITS-1:0]);
            res.write_data = expw; nxt.phase = DS_W1;
          end
          DS_W1, DS_W2: begin
            res.mem_op = OP_READ; res.mem_address = waddr(a0, st.widx[ADDR_BITS-1:0]);
            nxt.phase = (st.phase == DS_W1) ? DS_R1 : DS_R2;
          end
          DS_R1, DS_R2: begin
            res.mem_op = OP_WRITE; res.mem_address = waddr(a0, st.widx[ADDR_BITS-1:0]);
            if (rd != st.pat) begin
              if (!st.failed) begin
                nxt.failed = 1'b1; nxt.f_sub = SUB_DEV; nxt.f_addr = res.mem_address;
                nxt.f_exp = st.pat; nxt.f_act = rd;
              end
              res.write_data = st.orig; nxt.phase = PH_END;
            end else if (st.phase == DS_R1) begin
              nxt.pat = ~st.pat; res.write_data = ~st.pat; nxt.phase = DS_W2;
            end else begin
              res.write_data = st.orig; nxt.phase = DS_WO;
            end
          end
          DS_WO: begin
            nxt.widx = ni;
            if (ni < cfg.region_words) f_dsword = 1'b1;
            else f_fin = 1'b1;
          end
          default: nxt.phase = PH_IDLE;
        endcase
      end
      default: ;
    endcase

    // address bus fall-through chain
    if (mism && !st.failed) begin
      nxt.failed = 1'b1; nxt.f_sub = SUB_ADDR; nxt.f_addr = waddr(a0, roff);
      nxt.f_exp = PAT_A; nxt.f_act = rd;
    end
    if (f_wa) begin
      if (a_found) begin
        nxt.stuck = a_off; res.mem_op = OP_WRITE; res.mem_address = waddr(a0, a_off);
        res.write_data = PAT_A; nxt.phase = AB_WA;
      end else f_b5 = 1'b1;
    end
    if (f_b5) begin
      if (skip0) f_verb = 1'b1;
      else begin
        res.mem_op = OP_WRITE; res.mem_address = a0; res.write_data = PAT_5;
        nxt.phase = AB_W5;
      end
    end
    if (f_vera) begin
      if (a_found) begin
        nxt.stuck = a_off; res.mem_op = OP_READ; res.mem_address = waddr(a0, a_off);
        nxt.phase = AB_VR;
      end else f_basea = 1'b1;
    end
    if (f_verb) begin
      if (b_found) begin
        nxt.stuck = b_off; res.mem_op = OP_READ; res.mem_address = waddr(a0, b_off);
        res.write_data = '0; nxt.phase = AB_VR;
      end else f_basea = 1'b1;
    end
    if (f_basea) begin
      if (skip0) f_restore = 1'b1;
      else begin
        res.mem_op = OP_WRITE; res.mem_address = a0; res.write_data = PAT_A;
        nxt.phase = AB_WBA;
      end
    end
    if (f_testa) begin
      if (a_found) begin
        nxt.probe = a_off; res.mem_op = OP_WRITE; res.mem_address = waddr(a0, a_off);
        res.write_data = PAT_5; nxt.phase = AB_TW;
      end else f_restore = 1'b1;
    end
    if (f_innera) begin
      if (a_found) begin
        nxt.stuck = a_off; res.mem_op = OP_READ; res.mem_address = waddr(a0, a_off);
        nxt.phase = AB_TRO;
      end else begin
        res.mem_op = OP_WRITE; res.mem_address = waddr(a0, st.probe);
        res.write_data = PAT_A; nxt.phase = AB_TWA;
      end
    end
    // the base word may be saved in this same step
    if (f_restore) begin
      nxt.widx = REGION_BITS'(1); res.mem_op = OP_WRITE; res.mem_address = a0;
      if (nxt.save_cnt == '0) res.write_data = '0;
      else if (sv_wr.we && sv_wr.idx == '0) res.write_data = rd;
      else res.write_data = saved0;
      nxt.phase = AB_RS;
    end

    // run end and device test entry
    if (f_after) begin
      if (nxt.failed || cfg.quick_mode) f_fin = 1'b1;
      else f_dev = 1'b1;
    end
    if (f_dev) begin
      nxt.subtest = SUB_DEV; nxt.widx = '0;
      if (st.cancel || cfg.region_words == '0) f_fin = 1'b1;
      else if (cfg.device_safe) f_dsword = 1'b1;
      else begin
        res.mem_op = OP_WRITE; res.mem_address = a0; res.write_data = DATA_BITS'(1);
        nxt.phase = DD_W;
      end
    end
    if (f_dsword) begin
      if (nxt.widx[GAP_BITS-1:0] == '0 && st.cancel) f_fin = 1'b1;
      else begin
        res.mem_op = OP_READ; res.mem_address = waddr(a0, nxt.widx[ADDR_BITS-1:0]);
        nxt.phase = DS_RO;
      end
    end
    if (f_fin) begin
      res.mem_op = OP_DONE; res.mem_address = '0; res.write_data = '0;
      nxt.status = nxt.failed ? ST_FAIL : (st.cancel ? ST_SKIP : ST_PASS);
      nxt.phase = PH_IDLE;
    end

    res.run_status    = nxt.status;
    res.fail_subtest  = nxt.f_sub;
    res.fail_address  = nxt.f_addr;
    res.expected_word = nxt.f_exp;
    res.actual_word   = nxt.f_act;
  end
endmodule

// File: rtl/memory_test_sequencer_top.sv
// Memory self-test sequencer. Send a start command, then one step command per cycle; each
// step carries the data of the read issued on the step before and is answered by exactly one
// memory access (idle, read, write, or run finished) plus the run status and the first
// failure record. One item per cycle, back to back: every item is handled in a single pass
// between the sequencer state and the result register, so the rate is one access per cycle
// as long as the result side keeps taking transfers. A cancel command is answered with idle
// and ends the run as skipped at the next checkpoint. Configuration is to be written through
// cfg_* only while no run is in progress; the block itself does not enforce this.
module memory_test_sequencer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  msq_in_if.sink                             in_ch,
  msq_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [msq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import msq_pkg::*;

  cfg_t                 cfg_r;
  state_t               st_r, st_nxt;
  res_t                 res_nxt, res_r;
  save_wr_t             sv_wr;
  logic                 out_valid_r, in_acc;
  logic [DATA_BITS-1:0] saved_r [SAVE_DEPTH];
  logic [DATA_BITS-1:0] saved_rd, saved0;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign saved_rd    = saved_r[st_r.widx[SAVE_IDX_W-1:0]];
  assign saved0      = saved_r[0];

  msq_step u_step (
    .cfg(cfg_r), .st(st_r), .command(in_ch.command), .rd(in_ch.read_data),
    .saved_rd(saved_rd), .saved0(saved0), .nxt(st_nxt), .res(res_nxt), .sv_wr(sv_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{base_word: '0, region_words: REGION_BITS'(1) << ADDR_BITS,
                 quick_mode: 1'b0, device_safe: 1'b0, skip_low: '0, skip_high: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_WORD:    cfg_r.base_word    <= cfg_wdata[ADDR_BITS-1:0];
        CFG_REGION_WORDS: cfg_r.region_words <= cfg_wdata;
        CFG_QUICK_MODE:   cfg_r.quick_mode   <= cfg_wdata[0];
        CFG_DEVICE_SAFE:  cfg_r.device_safe  <= cfg_wdata[0];
        CFG_SKIP_LOW:     cfg_r.skip_low     <= cfg_wdata;
        CFG_SKIP_HIGH:    cfg_r.skip_high    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      st_r        <= st_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res_r <= res_nxt;
    if (in_acc && sv_wr.we) saved_r[sv_wr.idx] <= sv_wr.data;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mem_op        = res_r.mem_op;
  assign out_ch.mem_address   = res_r.mem_address;
  assign out_ch.write_data    = res_r.write_data;
  assign out_ch.run_status    = res_r.run_status;
  assign out_ch.fail_subtest  = res_r.fail_subtest;
  assign out_ch.fail_address  = res_r.fail_address;
  assign out_ch.expected_word = res_r.expected_word;
  assign out_ch.actual_word   = res_r.actual_word;

  // a start always opens with a read of the base word
  a_start_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.command == CMD_START |=> out_ch.valid && out_ch.mem_op == OP_READ)
    else $error("start did not issue a read");

  // a step with no run in progress yields idle
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.command == CMD_STEP && st_r.phase == PH_IDLE
    |=> out_ch.mem_op == OP_IDLE)
    else $error("step while idle issued an access");

  // a final status is only held while no run is active
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.status != ST_RUN |-> st_r.phase == PH_IDLE)
    else $error("final status during a run");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output");
endmodule

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 600000;
  localparam bit [63:0] ADDR_MASK = 64'h3F_FFFF;

  class msq_scoreboard;
    bit [21:0] base_word;
    bit [22:0] region_words, skip_lo, skip_hi;
    bit quick, safe;
    phase_t ph;
    bit [1:0] status, f_sub;
    bit [63:0] probe, stuck, widx;
    int save_cnt;
    bit [31:0] pat, orig, f_exp, f_act;
    bit [21:0] f_addr;
    bit [31:0] saved [SAVE_DEPTH];
    bit failed, cancel;
    res_t nxt;
    res_t expected_q[$];
    int mismatches, matched, passes, fails, skips;

    function new();
      base_word = '0; region_words = 23'd4194304; quick = 0; safe = 0;
      skip_lo = '0; skip_hi = '0;
      ph = PH_IDLE; status = ST_RUN; f_sub = '0; probe = '0; stuck = '0; widx = '0;
      save_cnt = 0; pat = '0; orig = '0; f_exp = '0; f_act = '0; f_addr = '0;
      failed = 0; cancel = 0; nxt = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [22:0] v);
      case (idx)
        CFG_BASE_WORD:    base_word = v[21:0];
        CFG_REGION_WORDS: region_words = v;
        CFG_QUICK_MODE:   quick = v[0];
        CFG_DEVICE_SAFE:  safe = v[0];
        CFG_SKIP_LOW:     skip_lo = v;
        CFG_SKIP_HIGH:    skip_hi = v;
        default: ;
      endcase
    endfunction

    function bit [21:0] word_at(bit [63:0] off);
      return base_word + off[21:0];
    endfunction

    function bit off_ok(bit [63:0] o);
      return (o & ((64'(region_words) - 64'd1) & ADDR_MASK)) != 0;
    endfunction

    function bit in_window(bit [21:0] a);
      return skip_hi > skip_lo && {1'b0, a} >= skip_lo && {1'b0, a} < skip_hi;
    endfunction

    function bit [31:0] dev_pattern(bit [63:0] i);
      return i[31:0] + 32'd1;
    endfunction

    function void emit(logic [1:0] op, bit [21:0] a, bit [31:0] d, phase_t n);
      nxt.mem_op = op; nxt.mem_address = a; nxt.write_data = d; ph = n;
    endfunction

    function void record_fail(logic [1:0] s, bit [21:0] a, bit [31:0] e, bit [31:0] r);
      if (!failed) begin
        failed = 1; f_sub = s; f_addr = a; f_exp = e; f_act = r;
      end
    endfunction

    function void finish_run();
      nxt.mem_op = OP_DONE; nxt.mem_address = '0; nxt.write_data = '0;
      status = failed ? ST_FAIL : (cancel ? ST_SKIP : ST_PASS);
      ph = PH_IDLE;
      if (status == ST_FAIL) fails++;
      else if (status == ST_SKIP) skips++;
      else passes++;
    endfunction

    function void ds_word();
      if (widx[11:0] == 0 && cancel) finish_run();
      else emit(OP_READ, word_at(widx), '0, DS_RO);
    endfunction

    function void dev_start();
      widx = '0;
      if (cancel || region_words == 0) finish_run();
      else if (safe) ds_word();
      else emit(OP_WRITE, word_at(0), dev_pattern(0), DD_W);
    endfunction

    function void after_addr();
      if (failed || quick) finish_run();
      else dev_start();
    endfunction

    function void ab_restore();
      widx = 1;
      emit(OP_WRITE, word_at(0), save_cnt != 0 ? saved[0] : '0, AB_RS);
    endfunction

    function void ab_inner(bit [63:0] o);
      for (; off_ok(o); o = o << 1)
        if (o != probe && !in_window(word_at(o))) begin
          stuck = o;
          emit(OP_READ, word_at(o), '0, AB_TRO);
          return;
        end
      emit(OP_WRITE, word_at(probe), PAT_A, AB_TWA);
    endfunction

    function void ab_test(bit [63:0] t);
      for (; off_ok(t); t = t << 1)
        if (!in_window(word_at(t))) begin
          probe = t;
          emit(OP_WRITE, word_at(t), PAT_5, AB_TW);
          return;
        end
      ab_restore();
    endfunction

    function void ab_base_a();
      if (in_window(word_at(0))) ab_restore();
      else emit(OP_WRITE, word_at(0), PAT_A, AB_WBA);
    endfunction

    function void ab_verify(bit [63:0] o);
      for (; off_ok(o); o = o << 1)
        if (!in_window(word_at(o))) begin
          stuck = o;
          emit(OP_READ, word_at(o), '0, AB_VR);
          return;
        end
      ab_base_a();
    endfunction

    function void ab_base5();
      if (in_window(word_at(0))) ab_verify(1);
      else emit(OP_WRITE, word_at(0), PAT_5, AB_W5);
    endfunction

    function void ab_write_a(bit [63:0] o);
      for (; off_ok(o); o = o << 1)
        if (!in_window(word_at(o))) begin
          stuck = o;
          emit(OP_WRITE, word_at(o), PAT_A, AB_WA);
          return;
        end
      ab_base5();
    endfunction

    function void ab_start();
      if (cancel) begin
        finish_run();
        return;
      end
      widx = '0; save_cnt = 0;
      emit(OP_READ, word_at(0), '0, AB_SAVE);
    endfunction

    function void advance(bit [31:0] rd);
      bit [31:0] want;
      case (ph)
        PH_END: finish_run();
        DB_ORIG: begin
          orig = rd; pat = 32'd1;
          emit(OP_WRITE, word_at(0), 32'd1, DB_WR);
        end
        DB_WR: emit(OP_READ, word_at(0), '0, DB_RD);
        DB_RD: begin
          if (rd != pat) begin
            record_fail(SUB_DATA, word_at(0), pat, rd);
            emit(OP_WRITE, word_at(0), orig, PH_END);
          end else begin
            pat = pat << 1;
            if (pat != 0) emit(OP_WRITE, word_at(0), pat, DB_WR);
            else emit(OP_WRITE, word_at(0), orig, DB_RESTORE);
          end
        end
        DB_RESTORE: ab_start();
        AB_SAVE: begin
          if (widx < SAVE_DEPTH) saved[widx] = rd;
          widx++;
          save_cnt = int'(widx);
          if (widx < SAVE_DEPTH && off_ok(64'd1 << (widx - 1)))
            emit(OP_READ, word_at(64'd1 << (widx - 1)), '0, AB_SAVE);
          else ab_write_a(1);
        end
        AB_WA: ab_write_a(stuck << 1);
        AB_W5: ab_verify(1);
        AB_VR: begin
          if (rd != PAT_A) begin
            record_fail(SUB_ADDR, word_at(stuck), PAT_A, rd);
            ab_restore();
          end else ab_verify(stuck << 1);
        end
        AB_WBA: ab_test(1);
        AB_TW: emit(OP_READ, word_at(0), '0, AB_TRB);
        AB_TRB: begin
          if (rd != PAT_A) begin
            record_fail(SUB_ADDR, word_at(probe), PAT_A, rd);
            ab_restore();
          end else ab_inner(1);
        end
        AB_TRO: begin
          if (rd != PAT_A) begin
            record_fail(SUB_ADDR, word_at(stuck), PAT_A, rd);
            ab_restore();
          end else ab_inner(stuck << 1);
        end
        AB_TWA: ab_test(probe << 1);
        AB_RS: begin
          if (widx < save_cnt && widx < SAVE_DEPTH) begin
            emit(OP_WRITE, word_at(64'd1 << (widx - 1)), saved[widx], AB_RS);
            widx++;
          end else after_addr();
        end
        DD_W: begin
          widx++;
          if (widx < region_words) emit(OP_WRITE, word_at(widx), dev_pattern(widx), DD_W);
          else begin
            widx = '0;
            emit(OP_READ, word_at(0), '0, DD_R1);
          end
        end
        DD_R1: begin
          want = dev_pattern(widx);
          if (rd != want) begin
            record_fail(SUB_DEV, word_at(widx), want, rd);
            finish_run();
          end else emit(OP_WRITE, word_at(widx), ~want, DD_WI);
        end
        DD_WI: begin
          widx++;
          if (widx < region_words) emit(OP_READ, word_at(widx), '0, DD_R1);
          else begin
            widx = '0;
            emit(OP_READ, word_at(0), '0, DD_R2);
          end
        end
        DD_R2: begin
          want = ~dev_pattern(widx);
          if (rd != want) begin
            record_fail(SUB_DEV, word_at(widx), want, rd);
            finish_run();
          end else begin
            widx++;
            if (widx < region_words) emit(OP_READ, word_at(widx), '0, DD_R2);
            else finish_run();
          end
        end
        DS_RO: begin
          orig = rd; pat = dev_pattern(widx);
          emit(OP_WRITE, word_at(widx), pat, DS_W1);
        end
        DS_W1: emit(OP_READ, word_at(widx), '0, DS_R1);
        DS_R1, DS_R2: begin
          if (rd != pat) begin
            record_fail(SUB_DEV, word_at(widx), pat, rd);
            emit(OP_WRITE, word_at(widx), orig, PH_END);
          end else if (ph == DS_R1) begin
            pat = ~pat;
            emit(OP_WRITE, word_at(widx), pat, DS_W2);
          end else emit(OP_WRITE, word_at(widx), orig, DS_WO);
        end
        DS_W2: emit(OP_READ, word_at(widx), '0, DS_R2);
        DS_WO: begin
          widx++;
          if (widx < region_words) ds_word();
          else finish_run();
        end
        default: ph = PH_IDLE;
      endcase
    endfunction

    // works out the result of one accepted input transfer and queues it
    function res_t note_input(logic [1:0] cmd, bit [31:0] rd);
      nxt = '0;
      case (cmd)
        CMD_START: begin
          failed = 0; cancel = 0; status = ST_RUN;
          f_sub = '0; f_addr = '0; f_exp = '0; f_act = '0;
          emit(OP_READ, word_at(0), '0, DB_ORIG);
        end
        CMD_CANCEL: if (ph != PH_IDLE) cancel = 1;
        CMD_STEP: if (ph != PH_IDLE) advance(rd);
        default: ;
      endcase
      nxt.run_status = status;
      nxt.fail_subtest = f_sub;
      nxt.fail_address = f_addr;
      nxt.expected_word = f_exp;
      nxt.actual_word = f_act;
      expected_q.push_back(nxt);
      return nxt;
    endfunction

    function void check_result(res_t got);
      res_t want;
      logic [31:0] e [8], a [8];
      string names [8];
      bit bad;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result transfer: op %0d addr %h",
                                      got.mem_op, got.mem_address);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      names = '{"mem_op", "mem_address", "write_data", "run_status", "fail_subtest",
                "fail_address", "expected_word", "actual_word"};
      e = '{want.mem_op, want.mem_address, want.write_data, want.run_status,
            want.fail_subtest, want.fail_address, want.expected_word, want.actual_word};
      a = '{got.mem_op, got.mem_address, got.write_data, got.run_status,
            got.fail_subtest, got.fail_address, got.expected_word, got.actual_word};
      bad = 0;
      for (int i = 0; i < 8; i++)
        if (a[i] !== e[i]) begin
          if (mismatches < 10)
            $display("mismatch on %s: expected %h, got %h", names[i], e[i], a[i]);
          bad = 1;
        end
      if (bad) mismatches++;
      else matched++;
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  msq_in_if in_ch ();
  msq_out_if out_ch ();

  memory_test_sequencer_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  msq_scoreboard sb = new();
  bit [31:0] mem_image [bit [21:0]];
  bit [31:0] read_back;
  int cyc, burst_left, step_items, fault_div, sessions;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cyc);
      $display("memory_test_sequencer_top test failed");
      $finish;
    end
  end

  // receiver stalls: steady, random, periodic and long-stall stretches
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else case ((cyc / 300) % 4)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= (cyc % 8) >= 3;
      default: out_ch.ready <= (cyc % 40) < 28;
    endcase
  end

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.mem_op, out_ch.mem_address, out_ch.write_data,
                        out_ch.run_status, out_ch.fail_subtest, out_ch.fail_address,
                        out_ch.expected_word, out_ch.actual_word});

  // called at a falling edge, returns at a falling edge
  task automatic send(logic [1:0] cmd, bit [31:0] rd);
    res_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.read_data <= rd;
    do @(posedge clk); while (!in_ch.ready);
    r = sb.note_input(cmd, rd);
    // memory image answers the read issued by this transfer on the next step
    if (r.mem_op == OP_WRITE) begin
      mem_image[r.mem_address] = r.write_data;
      read_back = $urandom;
    end else if (r.mem_op == OP_READ) begin
      if (!mem_image.exists(r.mem_address)) mem_image[r.mem_address] = $urandom;
      read_back = mem_image[r.mem_address];
      if (fault_div > 0 && $urandom_range(1, fault_div) == 1)
        read_back ^= 32'd1 << $urandom_range(0, 31);
    end else if (r.mem_op == OP_DONE) read_back = $urandom;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [22:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic setup(bit [21:0] base, bit [22:0] region, bit q, bit s,
                       bit [22:0] lo, bit [22:0] hi);
    drain();
    write_reg(CFG_BASE_WORD, {1'b0, base});
    write_reg(CFG_REGION_WORDS, region);
    write_reg(CFG_QUICK_MODE, {22'd0, q});
    write_reg(CFG_DEVICE_SAFE, {22'd0, s});
    write_reg(CFG_SKIP_LOW, lo);
    write_reg(CFG_SKIP_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  task automatic run_session(bit noisy);
    int steps;
    sessions++;
    send(CMD_START, $urandom);
    steps = 0;
    while (sb.nxt.mem_op != OP_DONE && steps < 4000) begin
      if (noisy && $urandom_range(0, 39) == 0) send(CMD_UNUSED, $urandom);
      else if (noisy && $urandom_range(0, 79) == 0) send(CMD_CANCEL, $urandom);
      else if (noisy && $urandom_range(0, 299) == 0) send(CMD_START, $urandom);
      else begin
        send(CMD_STEP, read_back);
        steps++;
        step_items++;
      end
    end
  endtask

  initial begin
    bit [21:0] base;
    bit [22:0] region, lo;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.command = CMD_STEP; in_ch.read_data = '0;
    cyc = 0; burst_left = 0; step_items = 0; fault_div = 0; sessions = 0;
    read_back = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle-time commands change nothing
    send(CMD_STEP, 32'hFFFF_FFFF);
    send(CMD_CANCEL, 32'h0);
    send(CMD_UNUSED, 32'hFFFF_FFFF);

    // full address space, quick mode, top base address wrapping, upper offsets protected
    setup(22'h3F_FFFF, 23'd4194304, 1, 0, 23'h100, 23'd4194304);
    run_session(0);
    // protected window covering the whole space
    setup(22'd0, 23'd4194304, 1, 1, 23'd0, 23'd4194304);
    run_session(0);
    // region size zero: all-ones mask, empty device test
    setup(22'd100, 23'd0, 0, 0, 23'd0, 23'd4194304);
    run_session(0);
    // single word, safe device test, cancel right after start
    setup(22'd5, 23'd1, 0, 1, 23'd6, 23'd9);
    sessions++;
    send(CMD_START, 32'h0);
    send(CMD_CANCEL, 32'h0);
    while (sb.nxt.mem_op != OP_DONE) begin
      send(CMD_STEP, read_back);
      step_items++;
    end

    while (step_items < 450) begin
      base = ($urandom_range(0, 4) == 0) ? 22'h3F_FFF0 + 22'($urandom_range(0, 15))
                                          : 22'($urandom);
      case ($urandom_range(0, 6))
        0: region = 23'd1;
        1: region = 23'd2;
        2: region = 23'd8;
        3: region = 23'd16;
        4: region = 23'($urandom_range(3, 20));
        5: region = 23'd32;
        default: region = 23'd4;
      endcase
      lo = ($urandom_range(0, 1) == 0) ? {1'b0, base} + 23'($urandom_range(0, 6))
                                       : 23'($urandom);
      fault_div = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 200);
      setup(base, region, $urandom_range(0, 3) == 0, $urandom_range(0, 1),
            lo, lo + 23'($urandom_range(0, 3)));
      run_session($urandom_range(0, 2) != 0);
    end

    // hold off until every result is back
    drain();
    repeat (20) @(posedge clk);
    $display("%0d runs: %0d passed, %0d failed, %0d skipped; %0d results checked",
             sessions, sb.passes, sb.fails, sb.skips, sb.matched);
    $display("%0d mismatching results", sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("memory_test_sequencer_top test passed");
    else
      $display("memory_test_sequencer_top test failed");
    $finish;
  end

endmodule

// File: memory_test_sequencer_top.f
rtl/msq_pkg.sv
rtl/msq_in_if.sv
rtl/msq_out_if.sv
rtl/msq_offset_scan.sv
rtl/msq_step.sv
rtl/memory_test_sequencer_top.sv
test/tb.sv
